// ===== design/smx_pkg.sv =====
package smx_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int LOCAL_COUNT = 8;

	localparam int WORD_W  = 32;
	localparam int OP_W    = 4;
	localparam int IMM_W   = 8;
	localparam int ADDR_W  = 16;
	localparam int ST_W    = 3;
	localparam int DEPTH_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int LOC_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
	localparam logic [IMM_W:0] LOCAL_LIM = (IMM_W + 1)'(LOCAL_COUNT);
	localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

	// opcodes
	localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
	localparam logic [OP_W-1:0] OP_PUSH = 4'd1;
	localparam logic [OP_W-1:0] OP_ADD  = 4'd2;
	localparam logic [OP_W-1:0] OP_SUB  = 4'd3;
	localparam logic [OP_W-1:0] OP_DUP  = 4'd4;
	localparam logic [OP_W-1:0] OP_DROP = 4'd5;
	localparam logic [OP_W-1:0] OP_SWAP = 4'd6;
	localparam logic [OP_W-1:0] OP_JMP  = 4'd7;
	localparam logic [OP_W-1:0] OP_JZ   = 4'd8;
	localparam logic [OP_W-1:0] OP_HOST = 4'd9;
	localparam logic [OP_W-1:0] OP_LGET = 4'd10;
	localparam logic [OP_W-1:0] OP_LSET = 4'd11;
	localparam logic [OP_W-1:0] OP_EQ   = 4'd12;
	localparam logic [OP_W-1:0] OP_LT   = 4'd13;
	localparam logic [OP_W-1:0] OP_HALT = 4'd14;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_HALT    = 3'd1;
	localparam logic [ST_W-1:0] ST_OVER    = 3'd2;
	localparam logic [ST_W-1:0] ST_UNDER   = 3'd3;
	localparam logic [ST_W-1:0] ST_RANGE   = 3'd4;
	localparam logic [ST_W-1:0] ST_BAD     = 3'd5;
	localparam logic [ST_W-1:0] ST_HOSTERR = 3'd6;
	localparam logic [ST_W-1:0] ST_HOSTREQ = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_ENABLED = 1'd1;

	typedef enum logic [2:0] {
		SK_NONE,
		SK_PUSH,
		SK_POP,
		SK_REPLACE,
		SK_SWAP
	} stk_op_t;

	typedef struct packed {
		stk_op_t           stk_op;
		logic [WORD_W-1:0] stk_val;
		logic              loc_we;
		logic [LOC_W-1:0]  loc_idx;
		logic [WORD_W-1:0] loc_data;
	} exec_ctl_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic               jump_taken;
		logic [ADDR_W-1:0]  next_target;
		logic [WORD_W-1:0]  top_value;
		logic [DEPTH_W-1:0] depth;
		logic [IMM_W-1:0]   host_id;
	} result_t;

endpackage

// ===== design/stack_machine_executor.sv =====
// Executes one decoded stack-machine instruction per accepted word and returns one
// result word for each. A word moves from the input register through the decode and
// execute logic into the result register, so the block sustains one instruction per
// clock unless an untaken result on the output stalls it; each result holds on the
// output until taken. The stack is a register
// shift line whose top two entries feed the execute logic directly, so a word may
// depend on the one before it without any stall. A failing instruction changes no
// state. Write code_length and host_enabled only while no instruction is in flight.
module stack_machine_executor
	import smx_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          opcode,
	input  logic [IMM_W-1:0]         immediate,
	input  logic [ADDR_W-1:0]        jump_target,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ST_W-1:0]          status,
	output logic                     jump_taken,
	output logic [ADDR_W-1:0]        next_target,
	output logic signed [WORD_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       stack_depth,
	output logic [IMM_W-1:0]         host_id,
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	logic              valid_s1;
	logic [OP_W-1:0]   opcode_s1;
	logic [IMM_W-1:0]  imm_s1;
	logic [ADDR_W-1:0] target_s1;

	logic              valid_s2;
	result_t           res_s2;

	logic [ADDR_W-1:0] code_length_q;
	logic              host_enabled_q;

	logic              fire;
	exec_ctl_t         ctl;
	result_t           res;
	logic [SP_W-1:0]   sp;
	logic [WORD_W-1:0] top0;
	logic [WORD_W-1:0] top1;
	logic [WORD_W-1:0] loc_rd;

	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q  <= '0;
			host_enabled_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CODE_LENGTH:  code_length_q  <= cfg_data[ADDR_W-1:0];
				REG_HOST_ENABLED: host_enabled_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			imm_s1    <= immediate;
			target_s1 <= jump_target;
		end
	end

	smx_exec u_exec (
		.opcode       (opcode_s1),
		.immediate    (imm_s1),
		.jump_target  (target_s1),
		.sp           (sp),
		.top0         (top0),
		.top1         (top1),
		.loc_rd       (loc_rd),
		.code_length  (code_length_q),
		.host_enabled (host_enabled_q),
		.ctl          (ctl),
		.res          (res)
	);

	smx_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.ctl    (ctl),
		.sp     (sp),
		.top0   (top0),
		.top1   (top1)
	);

	smx_locals u_locals (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (fire),
		.ctl     (ctl),
		.rd_idx  (imm_s1[LOC_W-1:0]),
		.rd_data (loc_rd)
	);

	// hold the result until taken; load a new one whenever the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign jump_taken  = res_s2.jump_taken;
	assign next_target = res_s2.next_target;
	assign top_value   = res_s2.top_value;
	assign stack_depth = res_s2.depth;
	assign host_id     = res_s2.host_id;

endmodule

// ===== design/smx_stack.sv =====
module smx_stack
	import smx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  exec_ctl_t         ctl,
	output logic [SP_W-1:0]   sp,
	output logic [WORD_W-1:0] top0,
	output logic [WORD_W-1:0] top1
);

	// entry 0 is the top of stack; push shifts down, pop shifts up
	logic [WORD_W-1:0] entry_q [STACK_DEPTH];
	logic [SP_W-1:0]   sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (en) begin
			case (ctl.stk_op)
				SK_PUSH: sp_q <= sp_q + SP_W'(1);
				SK_POP, SK_REPLACE: sp_q <= sp_q - SP_W'(1);
				default: sp_q <= sp_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl.stk_op)
				SK_PUSH: begin
					entry_q[0] <= ctl.stk_val;
					for (int i = 1; i < STACK_DEPTH; i++) begin
						entry_q[i] <= entry_q[i-1];
					end
				end
				SK_POP: begin
					for (int i = 0; i < STACK_DEPTH - 1; i++) begin
						entry_q[i] <= entry_q[i+1];
					end
				end
				SK_REPLACE: begin
					entry_q[0] <= ctl.stk_val;
					for (int i = 1; i < STACK_DEPTH - 1; i++) begin
						entry_q[i] <= entry_q[i+1];
					end
				end
				SK_SWAP: begin
					entry_q[0] <= entry_q[1];
					entry_q[1] <= entry_q[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign sp   = sp_q;
	assign top0 = entry_q[0];
	assign top1 = entry_q[1];

endmodule

// ===== design/smx_locals.sv =====
module smx_locals
	import smx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  exec_ctl_t         ctl,
	input  logic [LOC_W-1:0]  rd_idx,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] slot_q [LOCAL_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOCAL_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else if (en && ctl.loc_we) begin
			slot_q[ctl.loc_idx] <= ctl.loc_data;
		end
	end

	// out-of-range index is only read by an instruction that fails
	always_comb begin
		rd_data = '0;
		if ({1'b0, rd_idx} < (LOC_W + 1)'(LOCAL_COUNT)) begin
			rd_data = slot_q[rd_idx];
		end
	end

endmodule

// ===== design/smx_exec.sv =====
module smx_exec
	import smx_pkg::*;
(
	input  logic [OP_W-1:0]   opcode,
	input  logic [IMM_W-1:0]  immediate,
	input  logic [ADDR_W-1:0] jump_target,
	input  logic [SP_W-1:0]   sp,
	input  logic [WORD_W-1:0] top0,
	input  logic [WORD_W-1:0] top1,
	input  logic [WORD_W-1:0] loc_rd,
	input  logic [ADDR_W-1:0] code_length,
	input  logic              host_enabled,
	output exec_ctl_t         ctl,
	output result_t           res
);

	logic              empty;
	logic              short;
	logic              full;
	logic              loc_ok;
	logic              tgt_ok;
	logic [SP_W-1:0]   sp_next;

	assign empty  = (sp == '0);
	assign short  = (sp < SP_W'(2));
	assign full   = (sp >= SP_FULL);
	assign loc_ok = ({1'b0, immediate} < LOCAL_LIM);
	assign tgt_ok = (jump_target < code_length);

	always_comb begin
		ctl.stk_op   = SK_NONE;
		ctl.stk_val  = '0;
		ctl.loc_we   = 1'b0;
		ctl.loc_idx  = LOC_W'(immediate);
		ctl.loc_data = top0;
		res.status      = ST_OK;
		res.jump_taken  = 1'b0;
		res.host_id     = '0;

		case (opcode)
			OP_NOP: begin
			end
			OP_PUSH: begin
				if (full) begin
					res.status = ST_OVER;
				end else begin
					ctl.stk_op  = SK_PUSH;
					ctl.stk_val = {{(WORD_W-IMM_W){immediate[IMM_W-1]}}, immediate};
				end
			end
			OP_ADD, OP_SUB, OP_EQ, OP_LT: begin
				if (short) begin
					res.status = ST_UNDER;
				end else begin
					ctl.stk_op = SK_REPLACE;
					case (opcode)
						OP_ADD:  ctl.stk_val = top1 + top0;
						OP_SUB:  ctl.stk_val = top1 - top0;
						OP_EQ:   ctl.stk_val = WORD_W'(top1 == top0);
						default: ctl.stk_val = WORD_W'($signed(top1) < $signed(top0));
					endcase
				end
			end
			OP_DUP: begin
				if (empty) begin
					res.status = ST_UNDER;
				end else if (full) begin
					res.status = ST_OVER;
				end else begin
					ctl.stk_op  = SK_PUSH;
					ctl.stk_val = top0;
				end
			end
			OP_DROP: begin
				if (empty) begin
					res.status = ST_UNDER;
				end else begin
					ctl.stk_op = SK_POP;
				end
			end
			OP_SWAP: begin
				if (short) begin
					res.status = ST_UNDER;
				end else begin
					ctl.stk_op = SK_SWAP;
				end
			end
			OP_JMP: begin
				if (!tgt_ok) begin
					res.status = ST_RANGE;
				end else begin
					res.jump_taken = 1'b1;
				end
			end
			OP_JZ: begin
				// a zero top with a bad target undoes the pop
				if (empty) begin
					res.status = ST_UNDER;
				end else if (top0 == '0 && !tgt_ok) begin
					res.status = ST_RANGE;
				end else begin
					ctl.stk_op     = SK_POP;
					res.jump_taken = (top0 == '0);
				end
			end
			OP_HOST: begin
				if (!host_enabled) begin
					res.status = ST_HOSTERR;
				end else begin
					res.status  = ST_HOSTREQ;
					res.host_id = immediate;
				end
			end
			OP_LGET: begin
				if (!loc_ok) begin
					res.status = ST_BAD;
				end else if (full) begin
					res.status = ST_OVER;
				end else begin
					ctl.stk_op  = SK_PUSH;
					ctl.stk_val = loc_rd;
				end
			end
			OP_LSET: begin
				if (!loc_ok) begin
					res.status = ST_BAD;
				end else if (empty) begin
					res.status = ST_UNDER;
				end else begin
					ctl.stk_op = SK_POP;
					ctl.loc_we = 1'b1;
				end
			end
			OP_HALT: begin
				res.status = ST_HALT;
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase

		res.next_target = res.jump_taken ? jump_target : '0;

		// top and depth as they stand after this word
		case (ctl.stk_op)
			SK_PUSH: begin
				sp_next       = sp + SP_W'(1);
				res.top_value = ctl.stk_val;
			end
			SK_POP: begin
				sp_next       = sp - SP_W'(1);
				res.top_value = short ? '0 : top1;
			end
			SK_REPLACE: begin
				sp_next       = sp - SP_W'(1);
				res.top_value = ctl.stk_val;
			end
			SK_SWAP: begin
				sp_next       = sp;
				res.top_value = top1;
			end
			default: begin
				sp_next       = sp;
				res.top_value = empty ? '0 : top0;
			end
		endcase
		res.depth = DEPTH_W'(sp_next);
	end

endmodule
